>>> src/trial_division_factorizer_top_macros.svh
// assertion macros for the trial division factorizer checker
// no dependencies; included by the checker file only
`ifndef TRIAL_DIVISION_FACTORIZER_TOP_MACROS_SVH
`define TRIAL_DIVISION_FACTORIZER_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define TDF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tdf check failed");

// next-cycle implication, disabled during reset
`define TDF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tdf check failed");

`endif

>>> src/tdf_pkg.sv
// shared types and constants of the trial division factorizer
// no dependencies; used by the top level and the testbench
package tdf_pkg;

  localparam int MAX_RESULTS = 31;
  localparam int COUNT_W     = 5;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_NONE  = 6'b000010,
    S_TWOS  = 6'b000100,
    S_DIV   = 6'b001000,
    S_CHECK = 6'b010000,
    S_FINAL = 6'b100000
  } state_t;

endpackage

>>> src/trial_division_factorizer_top.sv
// trial division factorizer: sequencer with a bit-serial restoring divider
// depends on tdf_pkg
//
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall   | in_value
// out     | output    | out_valid/out_stall | out_factor, out_is_new, out_none_found, out_last
//
// one word in, one to 31 words out; a new word is taken once the last result is registered
// factors of two are split off in S_TWOS; each odd trial divisor runs the divider in S_DIV
// (one quotient bit per cycle) and is then tested in S_CHECK
// rst_n is synchronous; no clearing pass; out_stall holds the sequencer only when it emits
module trial_division_factorizer_top #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [VALUE_WIDTH-1:0] in_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [VALUE_WIDTH-1:0] out_factor,
  output logic                   out_is_new,
  output logic                   out_none_found,
  output logic                   out_last
);

  localparam int W     = VALUE_WIDTH;
  localparam int CNT_W = $clog2(VALUE_WIDTH);

  tdf_pkg::state_t state_r, state_nxt;
  logic [W-1:0] rem_r, rem_nxt;
  logic [W-1:0] div_r, div_nxt;
  logic [W-1:0] prev_r, prev_nxt;
  logic [W-1:0] part_r, part_nxt;
  logic [W-1:0] qsh_r, qsh_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [tdf_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic inner_r, inner_nxt;

  logic out_valid_r, out_valid_nxt;
  logic [W-1:0] out_factor_r, out_factor_nxt;
  logic out_is_new_r, out_is_new_nxt;
  logic out_none_r, out_none_nxt;
  logic out_last_r, out_last_nxt;

  logic out_free;
  logic cap_hit;
  logic [W:0] shifted;
  logic [W:0] diff;
  logic [W-1:0] rem_half;

  assign out_free = !out_valid_r || !out_stall;
  assign cap_hit  = (count_r == tdf_pkg::COUNT_W'(tdf_pkg::MAX_RESULTS - 1));
  assign shifted  = {part_r, qsh_r[W-1]};
  assign diff     = shifted - {1'b0, div_r};
  assign rem_half = rem_r >> 1;

  always_comb begin
    state_nxt      = state_r;
    rem_nxt        = rem_r;
    div_nxt        = div_r;
    prev_nxt       = prev_r;
    part_nxt       = part_r;
    qsh_nxt        = qsh_r;
    cnt_nxt        = cnt_r;
    count_nxt      = count_r;
    inner_nxt      = inner_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_factor_nxt = out_factor_r;
    out_is_new_nxt = out_is_new_r;
    out_none_nxt   = out_none_r;
    out_last_nxt   = out_last_r;
    case (state_r)
      tdf_pkg::S_IDLE: begin
        if (in_valid) begin
          rem_nxt   = in_value;
          prev_nxt  = '0;
          count_nxt = '0;
          if (in_value < W'(2)) begin
            state_nxt = tdf_pkg::S_NONE;
          end else begin
            state_nxt = tdf_pkg::S_TWOS;
          end
        end
      end
      tdf_pkg::S_NONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_factor_nxt = '0;
          out_is_new_nxt = 1'b0;
          out_none_nxt   = 1'b1;
          out_last_nxt   = 1'b1;
          state_nxt      = tdf_pkg::S_IDLE;
        end
      end
      tdf_pkg::S_TWOS: begin
        if (!rem_r[0]) begin
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_factor_nxt = W'(2);
            out_is_new_nxt = (prev_r != W'(2));
            out_none_nxt   = 1'b0;
            out_last_nxt   = (rem_half == W'(1)) || cap_hit;
            prev_nxt       = W'(2);
            rem_nxt        = rem_half;
            count_nxt      = count_r + 1'b1;
            if ((rem_half == W'(1)) || cap_hit) begin
              state_nxt = tdf_pkg::S_IDLE;
            end
          end
        end else begin
          div_nxt   = W'(3);
          inner_nxt = 1'b0;
          qsh_nxt   = rem_r;
          part_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = tdf_pkg::S_DIV;
        end
      end
      tdf_pkg::S_DIV: begin
        // one quotient bit per cycle
        if (!diff[W]) begin
          part_nxt = diff[W-1:0];
          qsh_nxt  = {qsh_r[W-2:0], 1'b1};
        end else begin
          part_nxt = shifted[W-1:0];
          qsh_nxt  = {qsh_r[W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(W - 1)) begin
          state_nxt = tdf_pkg::S_CHECK;
        end
      end
      tdf_pkg::S_CHECK: begin
        // qsh_r holds the quotient, part_r the remainder
        if (!inner_r && (div_r > qsh_r)) begin
          state_nxt = tdf_pkg::S_FINAL;
        end else if (part_r == '0) begin
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_factor_nxt = div_r;
            out_is_new_nxt = (prev_r != div_r);
            out_none_nxt   = 1'b0;
            out_last_nxt   = (qsh_r == W'(1)) || cap_hit;
            prev_nxt       = div_r;
            rem_nxt        = qsh_r;
            count_nxt      = count_r + 1'b1;
            inner_nxt      = 1'b1;
            part_nxt       = '0;
            cnt_nxt        = '0;
            if ((qsh_r == W'(1)) || cap_hit) begin
              state_nxt = tdf_pkg::S_IDLE;
            end else begin
              state_nxt = tdf_pkg::S_DIV;
            end
          end
        end else begin
          div_nxt   = div_r + W'(2);
          inner_nxt = 1'b0;
          qsh_nxt   = rem_r;
          part_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = tdf_pkg::S_DIV;
        end
      end
      tdf_pkg::S_FINAL: begin
        if (rem_r > W'(2)) begin
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_factor_nxt = rem_r;
            out_is_new_nxt = (prev_r != rem_r);
            out_none_nxt   = 1'b0;
            out_last_nxt   = 1'b1;
            prev_nxt       = rem_r;
            state_nxt      = tdf_pkg::S_IDLE;
          end
        end else begin
          state_nxt = tdf_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = tdf_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tdf_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      inner_r     <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
      inner_r     <= inner_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r        <= rem_nxt;
    div_r        <= div_nxt;
    prev_r       <= prev_nxt;
    part_r       <= part_nxt;
    qsh_r        <= qsh_nxt;
    out_factor_r <= out_factor_nxt;
    out_is_new_r <= out_is_new_nxt;
    out_none_r   <= out_none_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign in_stall       = (state_r != tdf_pkg::S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_factor     = out_factor_r;
  assign out_is_new     = out_is_new_r;
  assign out_none_found = out_none_r;
  assign out_last       = out_last_r;

endmodule

>>> src/tdf_checker.sv
// port-level checks for the trial division factorizer, bound to the top level
// depends on trial_division_factorizer_top_macros.svh
`include "trial_division_factorizer_top_macros.svh"

module tdf_checker #(
  parameter int VALUE_WIDTH = 32
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [VALUE_WIDTH-1:0] out_factor,
  input logic                   out_is_new,
  input logic                   out_none_found,
  input logic                   out_last
);

  // a word with no factors is a single zero word that closes its run
  `TDF_ASSERT_IMP(a_none_word, out_valid && out_none_found, (out_factor == '0) && out_last && !out_is_new)

  // every real factor is at least two
  `TDF_ASSERT_IMP(a_factor_min, out_valid && !out_none_found, out_factor >= VALUE_WIDTH'(2))

  // an accepted word keeps the block busy in the next cycle
  `TDF_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // a stalled result word holds
  `TDF_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_factor) && $stable(out_last))

endmodule

bind trial_division_factorizer_top tdf_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_tdf_checker (.*);

>>> verif/tb_trial_division_factorizer_top.sv
`timescale 1ns / 1ps
// testbench for trial_division_factorizer_top: directed and random words into the factorizer,
// every result word checked against a software factorization held in a scoreboard class
// depends on tdf_pkg and the factorizer rtl

typedef bit [31:0] word_t;

typedef struct {
  word_t factor;
  bit    is_new;
  bit    none_found;
  bit    last;
} factor_word_t;

class factor_scoreboard;
  factor_word_t pending_factors[$];
  factor_word_t run[$];
  int errors;
  int values_seen;
  int results_seen;
  int none_seen;
  int longest_run;

  function new();
    errors = 0;
    values_seen = 0;
    results_seen = 0;
    none_seen = 0;
    longest_run = 0;
  endfunction

  // appends one factor to the current run unless the run is full
  function bit add_factor(word_t f);
    factor_word_t w;
    if (run.size() >= tdf_pkg::MAX_RESULTS) return 1'b0;
    w.factor = f;
    w.is_new = (run.size() == 0) || (f != run[run.size()-1].factor);
    w.none_found = 1'b0;
    w.last = 1'b0;
    run = {run, w};
    return 1'b1;
  endfunction

  function void note_value(word_t v);
    word_t rem;
    word_t div;
    bit room;
    factor_word_t w;
    run.delete();
    rem = v;
    room = 1'b1;
    values_seen++;
    if (rem < 2) begin
      w.factor = '0;
      w.is_new = 1'b0;
      w.none_found = 1'b1;
      w.last = 1'b1;
      run = {run, w};
      none_seen++;
    end else begin
      while (room && !rem[0]) begin
        room = add_factor(2);
        if (room) rem = rem >> 1;
      end
      div = 3;
      while (room && div <= rem / div) begin
        while (room && rem % div == 0) begin
          room = add_factor(div);
          if (room) rem = rem / div;
        end
        div += 2;
      end
      if (room && rem > 2) room = add_factor(rem);
      run[run.size()-1].last = 1'b1;
    end
    if (run.size() > longest_run) longest_run = run.size();
    pending_factors = {pending_factors, run};
  endfunction

  function void compare_field(string name, word_t want, word_t got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  function void check_word(word_t factor, bit is_new, bit none_found, bit last);
    factor_word_t w;
    results_seen++;
    if (pending_factors.size() == 0) begin
      errors++;
      $display("%0t: result word with none expected, expected none, actual factor %0h",
               $time, factor);
      return;
    end
    w = pending_factors.pop_front();
    compare_field("factor", w.factor, factor);
    compare_field("is_new", word_t'(w.is_new), word_t'(is_new));
    compare_field("none_found", word_t'(w.none_found), word_t'(none_found));
    compare_field("last", word_t'(w.last), word_t'(last));
  endfunction
endclass

module tb_trial_division_factorizer_top;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int LONG_HOLD = 2000;
  localparam int DRAIN = 64;
  localparam int RANDOM_WORDS = 78;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_factor;
  logic        out_is_new;
  logic        out_none_found;
  logic        out_last;

  factor_scoreboard sb = new();
  int unsigned cycles = 0;

  word_t directed_values[22] = '{
    32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd9, 32'd25, 32'd49, 32'd12,
    32'd360, 32'h8000_0000, 32'hFFFF_FFFF, 32'd65521, 32'd65537, 32'd1000003,
    32'd3486784401, 32'd223092870, 32'd4294836225, 32'hAAAA_AAAA, 32'h5555_5555
  };

  int unsigned small_primes[25] = '{
    2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53, 59, 61, 67, 71, 73, 79,
    83, 89, 97
  };

  always #10 clk = ~clk;

  trial_division_factorizer_top #(
    .VALUE_WIDTH(32)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_factor(out_factor),
    .out_is_new(out_is_new),
    .out_none_found(out_none_found),
    .out_last(out_last)
  );

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_value(in_value);
    if (rst_n && out_valid && !out_stall)
      sb.check_word(out_factor, out_is_new, out_none_found, out_last);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d result words outstanding", $time,
               sb.pending_factors.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // called at a falling edge, returns at the falling edge after the word is taken
  task automatic send_word(input word_t v);
    in_valid <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin : stimulus
    longint unsigned acc;
    word_t value;
    word_t q;
    int unsigned p;
    int burst;
    int gap;
    int kind;
    int top;
    int n;
    bit prime;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_values[i]) send_word(directed_values[i]);

    n = 0;
    while (n < RANDOM_WORDS) begin
      burst = $urandom_range(1, 8);
      for (int b = 0; b < burst && n < RANDOM_WORDS; b++) begin
        kind = $urandom_range(0, 99);
        if (kind < 25) begin
          // short values, any bit pattern
          value = $urandom & ((32'h1 << $urandom_range(1, 16)) - 1);
        end else if (kind < 65) begin
          // smooth products that reach the upper bits
          top = $urandom_range(0, 24);
          acc = 64'd1;
          do begin
            p = small_primes[$urandom_range(0, top)];
            if (acc * p > 64'hFFFF_FFFF) break;
            acc = acc * p;
          end while ($urandom_range(0, 11) != 0);
          value = acc[31:0];
        end else if (kind < 85) begin
          // a larger prime cofactor with up to three small factors
          do begin
            q = $urandom_range(32'h1_0000, 32'h8_0000) | 32'h1;
            prime = 1'b1;
            for (int d = 3; d * d <= q; d += 2)
              if (q % d == 0) prime = 1'b0;
          end while (!prime);
          acc = 64'(q);
          repeat ($urandom_range(0, 3)) begin
            p = small_primes[$urandom_range(0, 24)];
            if (acc * p <= 64'hFFFF_FFFF) acc = acc * p;
          end
          value = acc[31:0];
        end else begin
          case ($urandom_range(0, 3))
            0: value = $urandom_range(0, 1);
            1: value = small_primes[$urandom_range(0, 24)];
            2: begin
              p = small_primes[$urandom_range(1, 24)];
              acc = 64'(p);
              while (acc * p <= 64'hFFFF_FFFF) acc = acc * p;
              value = acc[31:0];
            end
            default: value = $urandom_range(2, 1000);
          endcase
        end
        send_word(value);
        n++;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_factors.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("covered %0d values and %0d result words, %0d without factors, longest run %0d",
             sb.values_seen, sb.results_seen, sb.none_seen, sb.longest_run);
    $display("stimulus: edge values, smooth products, prime cofactors, one long output hold");
    if (sb.errors == 0 && sb.pending_factors.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : result_pacing
    int mode;
    int span;
    bit held_once;

    held_once = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 200);
      repeat (span) begin
        @(negedge clk);
        // hold the output long enough for the input side to back up
        if (!held_once && sb.results_seen >= 40) begin
          held_once = 1'b1;
          out_stall <= 1'b1;
          repeat (LONG_HOLD) @(negedge clk);
        end
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= 1'($urandom_range(0, 1));
          default: out_stall <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end
endmodule
